// ----- hdl/rri_pkg.sv -----
// Shared constants, types and helper functions of the ray and rectangle intersection block.
package rri_pkg;

   localparam int COORD_BITS    = 32;
   localparam int FRACTION_BITS = 16;

   localparam int BASIS_BITS = 18;
   localparam int PZ_BITS    = 16;
   localparam int RECT_BITS  = 15;

   localparam int DOT_W      = COORD_BITS + 2;
   localparam int PZ_SH_W    = PZ_BITS + FRACTION_BITS;
   localparam int NUM_W      = ((PZ_SH_W > DOT_W) ? PZ_SH_W : DOT_W) + 1;
   localparam int DIV_STAGES = COORD_BITS - 1;
   localparam int DVD_W      = NUM_W + FRACTION_BITS;
   localparam int OVF_W      = (DVD_W > DOT_W + COORD_BITS - 1) ? DVD_W
                                                               : DOT_W + COORD_BITS - 1;
   localparam int PROD_W     = 2 * COORD_BITS - 1;
   localparam int STEP_W     = COORD_BITS + 1;
   localparam int SUM_W      = COORD_BITS + 2;
   localparam int BOUND_W    = (PZ_BITS + 1 + FRACTION_BITS > DOT_W)
                               ? PZ_BITS + 1 + FRACTION_BITS : DOT_W;

   localparam int REQ_W = ((6 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((3 * COORD_BITS + 7) / 8) * 8;

   localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
   localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = BASIS_BITS;

   localparam logic [CSR_ADDR_W-1:0] CSR_BASIS        = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_X       = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_Y       = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PLANE_OFFSET = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_WIDTH   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECT_HEIGHT  = 3'd5;

   localparam logic [1:0] BASIS_POS = 2'b01;
   localparam logic [1:0] BASIS_NEG = 2'b11;

   localparam logic [BASIS_BITS-1:0] BASIS_RESET = 18'h10101;

   typedef logic [2:0][COORD_BITS-1:0] vec_type;

   typedef struct packed {
      vec_type o;
      vec_type d;
   } ray_type;

   typedef struct packed {
      ray_type ray;
      logic    miss;
   } side_type;

   typedef struct packed {
      side_type              side;
      logic                  ovf;
      logic [DOT_W-1:0]      b;
      logic [DOT_W-1:0]      r;
      logic [DIV_STAGES-1:0] q;
      logic [DIV_STAGES-1:0] dlow;
   } div_type;

   typedef struct packed {
      logic [BASIS_BITS-1:0]      basis;
      logic signed [PZ_BITS-1:0]  rect_x;
      logic signed [PZ_BITS-1:0]  rect_y;
      logic signed [PZ_BITS-1:0]  plane_offset;
      logic [RECT_BITS-1:0]       rect_width;
      logic [RECT_BITS-1:0]       rect_height;
   } cfg_type;

   function automatic logic signed [DOT_W-1:0] basis_term(input logic [1:0] code,
                                                           input logic signed [COORD_BITS-1:0] v);
      logic signed [DOT_W-1:0] ext;
      ext = DOT_W'(v);
      case (code)
         BASIS_POS: basis_term = ext;
         BASIS_NEG: basis_term = -ext;
         default:   basis_term = '0;
      endcase
   endfunction

   function automatic logic signed [DOT_W-1:0] row_dot(input logic [BASIS_BITS-1:0] basis,
                                                        input int row, input vec_type v);
      logic signed [DOT_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         acc = acc + basis_term(basis[2 * (3 * row + k) +: 2], $signed(v[k]));
      end
      row_dot = acc;
   endfunction

endpackage

// ----- hdl/ray_rectangle_intersect.sv -----
// Top level of the ray and rectangle intersection pipeline with its register file.
//
//   channel | direction | transfer contents
//   --------+-----------+--------------------------------------------------------
//   req     | in        | ray origin and direction, six signed Q16.16 words
//   rsp     | out       | hit flag in tuser, global hit point x, y, z in tdata
//   csr     | in        | register writes, index 0 to 5, no read-back
//
// One ray enters per cycle while rsp is not stalled; its result passes the front, divider and back stages.
// The divider resolves one quotient bit per stage.
// Every stage holds its own valid bit and advances whenever the next stage is free,
// so a stall on rsp fills empty slots first and loses or repeats nothing.
// Reset clears all valid bits and returns the registers to an identity basis
// and a unit square at the origin.
module ray_rectangle_intersect (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [rri_pkg::REQ_W-1:0]        req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // hit_x, hit_y, hit_z
   output logic [rri_pkg::RSP_W-1:0]        rsp_tdata,
   // hit
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [rri_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [rri_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rri_pkg::cfg_type cfg_ff, cfg_in;
   rri_pkg::ray_type ray;
   rri_pkg::div_type f2d_data, d2b_data;
   rri_pkg::vec_type point;
   logic             f2d_valid, f2d_ready, d2b_valid, d2b_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            rri_pkg::CSR_BASIS:        cfg_in.basis = csr_wdata;
            rri_pkg::CSR_RECT_X:       cfg_in.rect_x = csr_wdata[rri_pkg::PZ_BITS-1:0];
            rri_pkg::CSR_RECT_Y:       cfg_in.rect_y = csr_wdata[rri_pkg::PZ_BITS-1:0];
            rri_pkg::CSR_PLANE_OFFSET: cfg_in.plane_offset = csr_wdata[rri_pkg::PZ_BITS-1:0];
            rri_pkg::CSR_RECT_WIDTH:   cfg_in.rect_width = csr_wdata[rri_pkg::RECT_BITS-1:0];
            rri_pkg::CSR_RECT_HEIGHT:  cfg_in.rect_height = csr_wdata[rri_pkg::RECT_BITS-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.basis        <= rri_pkg::BASIS_RESET;
         cfg_ff.rect_x       <= '0;
         cfg_ff.rect_y       <= '0;
         cfg_ff.plane_offset <= '0;
         cfg_ff.rect_width   <= rri_pkg::RECT_BITS'(1);
         cfg_ff.rect_height  <= rri_pkg::RECT_BITS'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign ray.o = req_tdata[3*rri_pkg::COORD_BITS-1:0];
   assign ray.d = req_tdata[6*rri_pkg::COORD_BITS-1:3*rri_pkg::COORD_BITS];

   rri_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ray    (ray),
      .out_valid (f2d_valid),
      .out_ready (f2d_ready),
      .out_data  (f2d_data)
   );

   rri_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f2d_valid),
      .in_ready  (f2d_ready),
      .in_data   (f2d_data),
      .out_valid (d2b_valid),
      .out_ready (d2b_ready),
      .out_data  (d2b_data)
   );

   rri_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (d2b_valid),
      .in_ready  (d2b_ready),
      .in_data   (d2b_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_hit   (rsp_tuser),
      .out_point (point)
   );

   assign rsp_tdata = rri_pkg::RSP_W'(point);

endmodule

// ----- hdl/rri_front.sv -----
// Front stages: plane dot products, miss test on the approach rate and divider setup.
module rri_front (
   input  logic               clock,
   input  logic               reset,
   input  rri_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  rri_pkg::ray_type   in_ray,
   output logic               out_valid,
   input  logic               out_ready,
   output rri_pkg::div_type   out_data
);

   typedef struct packed {
      rri_pkg::ray_type                    ray;
      logic signed [rri_pkg::DOT_W-1:0]    den;
      logic signed [rri_pkg::DOT_W-1:0]    odot;
   } s1_type;

   typedef struct packed {
      rri_pkg::side_type                   side;
      logic [rri_pkg::NUM_W-1:0]           a;
      logic [rri_pkg::DOT_W-1:0]           b;
   } s2_type;

   s1_type           s1_ff, s1_in;
   s2_type           s2_ff, s2_in;
   rri_pkg::div_type s3_ff, s3_in;
   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic             s1_ready, s2_ready, s3_ready;

   logic signed [rri_pkg::NUM_W-1:0] num;
   logic [rri_pkg::DVD_W-1:0]        dv;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      s1_in.ray  = in_ray;
      s1_in.den  = rri_pkg::row_dot(cfg.basis, 2, in_ray.d);
      s1_in.odot = rri_pkg::row_dot(cfg.basis, 2, in_ray.o);
   end

   always_comb begin
      num = (rri_pkg::NUM_W'(cfg.plane_offset) <<< rri_pkg::FRACTION_BITS)
            - rri_pkg::NUM_W'(s1_ff.odot);
      s2_in.side.ray  = s1_ff.ray;
      s2_in.side.miss = (s1_ff.den == '0) ||
                        ((num != '0) && (num[rri_pkg::NUM_W-1] != s1_ff.den[rri_pkg::DOT_W-1]));
      s2_in.a = num[rri_pkg::NUM_W-1] ? rri_pkg::NUM_W'(-num) : rri_pkg::NUM_W'(num);
      s2_in.b = s1_ff.den[rri_pkg::DOT_W-1] ? rri_pkg::DOT_W'(-s1_ff.den)
                                             : rri_pkg::DOT_W'(s1_ff.den);
   end

   always_comb begin
      dv         = rri_pkg::DVD_W'(s2_ff.a) << rri_pkg::FRACTION_BITS;
      s3_in.side = s2_ff.side;
      s3_in.b    = s2_ff.b;
      s3_in.ovf  = rri_pkg::OVF_W'(dv) >=
                   (rri_pkg::OVF_W'(s2_ff.b) << (rri_pkg::COORD_BITS - 1));
      s3_in.r    = rri_pkg::DOT_W'(dv >> (rri_pkg::COORD_BITS - 1));
      s3_in.q    = '0;
      s3_in.dlow = dv[rri_pkg::DIV_STAGES-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= in_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) s1_ff <= s1_in;
      if (s2_ready) s2_ff <= s2_in;
      if (s3_ready) s3_ff <= s3_in;
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

// ----- hdl/rri_div.sv -----
// Pipelined restoring divider that produces one quotient bit of the ray parameter per stage.
module rri_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rri_pkg::div_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rri_pkg::div_type   out_data
);

   localparam int N = rri_pkg::DIV_STAGES;

   rri_pkg::div_type stage_ff [N];
   logic             valid_ff [N];
   logic             ready    [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      rri_pkg::div_type        prev, stage_in;
      logic                    prev_valid, next_ready, ge;
      logic [rri_pkg::DOT_W:0] rs, bx;

      if (k == 0) begin : g_first
         assign prev       = in_data;
         assign prev_valid = in_valid;
      end else begin : g_rest
         assign prev       = stage_ff[k-1];
         assign prev_valid = valid_ff[k-1];
      end

      if (k == N - 1) begin : g_last
         assign next_ready = out_ready;
      end else begin : g_mid
         assign next_ready = ready[k+1];
      end

      assign ready[k] = !valid_ff[k] || next_ready;

      always_comb begin
         rs             = {prev.r, prev.dlow[N-1-k]};
         bx             = {1'b0, prev.b};
         ge             = rs >= bx;
         stage_in       = prev;
         stage_in.r     = ge ? rri_pkg::DOT_W'(rs - bx) : rri_pkg::DOT_W'(rs);
         stage_in.q     = {prev.q[N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (ready[k]) stage_ff[k] <= stage_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[N-1];
   assign out_data  = stage_ff[N-1];

endmodule

// ----- hdl/rri_back.sv -----
// Back stages: hit point scaling and saturation, local projection and rectangle bounds test.
module rri_back (
   input  logic               clock,
   input  logic               reset,
   input  rri_pkg::cfg_type   cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  rri_pkg::div_type   in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic               out_hit,
   output rri_pkg::vec_type   out_point
);

   typedef struct packed {
      logic [2:0][rri_pkg::PROD_W-1:0] prod;
      logic [2:0]                      neg;
      rri_pkg::vec_type                o;
      logic                            miss;
   } b1_type;

   typedef struct packed {
      rri_pkg::vec_type hp;
      logic             miss;
   } b2_type;

   typedef struct packed {
      rri_pkg::vec_type                 hp;
      logic signed [rri_pkg::DOT_W-1:0] lx;
      logic signed [rri_pkg::DOT_W-1:0] ly;
      logic                             miss;
   } b3_type;

   typedef struct packed {
      logic             hit;
      rri_pkg::vec_type point;
   } b4_type;

   b1_type b1_ff, b1_in;
   b2_type b2_ff, b2_in;
   b3_type b3_ff, b3_in;
   b4_type b4_ff, b4_in;
   logic   v1_ff, v2_ff, v3_ff, v4_ff;
   logic   r1, r2, r3, r4;

   logic [rri_pkg::DIV_STAGES-1:0]  t;
   logic [rri_pkg::COORD_BITS-1:0]  dmag [3];
   logic [rri_pkg::PROD_W-1:0]      sh   [3];
   logic [rri_pkg::STEP_W-1:0]      step [3];
   logic signed [rri_pkg::SUM_W-1:0] sum [3];
   logic signed [rri_pkg::BOUND_W-1:0] lo_x, hi_x, lo_y, hi_y, lxw, lyw;

   localparam logic [rri_pkg::STEP_W-1:0] STEP_CAP =
      rri_pkg::STEP_W'(1) << rri_pkg::COORD_BITS;

   assign r4       = !v4_ff || out_ready;
   assign r3       = !v3_ff || r4;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_comb begin
      t = in_data.ovf ? '1 : in_data.q;
      for (int i = 0; i < 3; i++) begin
         b1_in.neg[i] = in_data.side.ray.d[i][rri_pkg::COORD_BITS-1];
         dmag[i] = b1_in.neg[i] ? -in_data.side.ray.d[i] : in_data.side.ray.d[i];
         b1_in.prod[i] = rri_pkg::PROD_W'(dmag[i]) * rri_pkg::PROD_W'(t);
      end
      b1_in.o    = in_data.side.ray.o;
      b1_in.miss = in_data.side.miss;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh[i]   = b1_ff.prod[i] >> rri_pkg::FRACTION_BITS;
         step[i] = (sh[i] > rri_pkg::PROD_W'(STEP_CAP)) ? STEP_CAP : rri_pkg::STEP_W'(sh[i]);
         sum[i]  = rri_pkg::SUM_W'($signed(b1_ff.o[i])) +
                   (b1_ff.neg[i] ? -$signed(rri_pkg::SUM_W'(step[i]))
                                 :  $signed(rri_pkg::SUM_W'(step[i])));
         if (sum[i] > rri_pkg::SAT_MAX) begin
            b2_in.hp[i] = rri_pkg::COORD_BITS'(rri_pkg::SAT_MAX);
         end else if (sum[i] < rri_pkg::SAT_MIN) begin
            b2_in.hp[i] = rri_pkg::COORD_BITS'(rri_pkg::SAT_MIN);
         end else begin
            b2_in.hp[i] = sum[i][rri_pkg::COORD_BITS-1:0];
         end
      end
      b2_in.miss = b1_ff.miss;
   end

   always_comb begin
      b3_in.hp   = b2_ff.hp;
      b3_in.lx   = rri_pkg::row_dot(cfg.basis, 0, b2_ff.hp);
      b3_in.ly   = rri_pkg::row_dot(cfg.basis, 1, b2_ff.hp);
      b3_in.miss = b2_ff.miss;
   end

   always_comb begin
      lo_x = rri_pkg::BOUND_W'(cfg.rect_x) <<< rri_pkg::FRACTION_BITS;
      lo_y = rri_pkg::BOUND_W'(cfg.rect_y) <<< rri_pkg::FRACTION_BITS;
      hi_x = (rri_pkg::BOUND_W'(cfg.rect_x) +
              rri_pkg::BOUND_W'($signed({1'b0, cfg.rect_width}))) <<< rri_pkg::FRACTION_BITS;
      hi_y = (rri_pkg::BOUND_W'(cfg.rect_y) +
              rri_pkg::BOUND_W'($signed({1'b0, cfg.rect_height}))) <<< rri_pkg::FRACTION_BITS;
      lxw  = rri_pkg::BOUND_W'(b3_ff.lx);
      lyw  = rri_pkg::BOUND_W'(b3_ff.ly);
      b4_in.hit   = !b3_ff.miss && (lxw >= lo_x) && (lyw >= lo_y) &&
                    (lxw <= hi_x) && (lyw <= hi_y);
      b4_in.point = b4_in.hit ? b3_ff.hp : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (r1) b1_ff <= b1_in;
      if (r2) b2_ff <= b2_in;
      if (r3) b3_ff <= b3_in;
      if (r4) b4_ff <= b4_in;
   end

   assign out_valid = v4_ff;
   assign out_hit   = b4_ff.hit;
   assign out_point = b4_ff.point;

endmodule

// ----- hdl/rri_chk.sv -----
// Port-level checker for the ray and rectangle intersection block, with its bind.
module rri_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rri_pkg::RSP_W-1:0]     rsp_tdata,
   input logic                          rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid directly after reset.");

   a_ready_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_tready)
      else $error("Input not ready on an empty pipeline.");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("Miss result carries a nonzero point.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("Stalled result changed.");

endmodule

bind ray_rectangle_intersect rri_chk u_rri_chk (.*);
